// ===== rtl/mhlr_pkg.sv =====
// ----------------------------------------------------------------------------
// mhlr_pkg: shared types and codes for the min-heap log repair block
// Word formats on both channels, operation codes, controller states and the
// command bundle that the controller sends to the row of cells.
// ----------------------------------------------------------------------------
package mhlr_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_GETMIN = 2'd2;

	localparam logic signed [31:0] FILL_VALUE = 32'sd1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] item_value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         op_code;
		logic signed [31:0] op_value;
		logic               last;
		logic               overflow;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_TAIL,
		S_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic signed [31:0] operand;
	} cell_ctl_t;

	typedef struct packed {
		logic present;
		logic head_below;
	} heap_stat_t;

endpackage

// ===== rtl/min_heap_log_repair_core.sv =====
// ----------------------------------------------------------------------------
// min_heap_log_repair_core: bounded min-priority store with log repair
// Keeps up to CAPACITY signed values in a sorted row of cells and turns each
// logged heap operation into the word stream a real min-heap would accept.
// ----------------------------------------------------------------------------
//   channel  dir  payload          handshake
//   req      in   req_word_t       req_valid / req_stall
//   rsp      out  rsp_word_t       rsp_valid / rsp_stall
//
// An item holds the block through capture and match search, then through its
// result words, one per cycle while the output register is not stalled, since
// the single output register and cell 0 decide one word at a time; a getMin
// emits an optional insert, its removals and then the getMin word. A word that
// is ready while the output register holds a stalled word waits for it.
// Reset clears the entry count, the sequencer and the output valid only.
// ----------------------------------------------------------------------------
module min_heap_log_repair_core #(
	parameter int CAPACITY = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  mhlr_pkg::req_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output mhlr_pkg::rsp_word_t  rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	mhlr_pkg::cell_ctl_t  ctl;
	mhlr_pkg::heap_stat_t stat;
	logic [CNT_W-1:0]     count;
	logic [CAPACITY-1:0]  occ, le, lt, hit;
	logic signed [31:0]   cell_value [CAPACITY];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			occ[i] = (CNT_W'(i) < count);
		end
	end

	assign stat.present    = |hit;
	assign stat.head_below = lt[0];

	mhlr_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.stat      (stat),
		.ctl       (ctl),
		.count     (count)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic               left_le_w;
		logic signed [31:0] left_w, right_w;
		if (g == 0) begin : g_head
			assign left_le_w = 1'b1;
			assign left_w    = ctl.operand;
		end else begin : g_body
			assign left_le_w = le[g-1];
			assign left_w    = cell_value[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_w = cell_value[g];
		end else begin : g_inner
			assign right_w = cell_value[g+1];
		end
		mhlr_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ[g]),
			.left_le     (left_le_w),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_value[g]),
			.le          (le[g]),
			.lt          (lt[g]),
			.hit         (hit[g])
		);
	end

endmodule

// ===== rtl/mhlr_cell.sv =====
// ----------------------------------------------------------------------------
// mhlr_cell: one slot of the sorted value row
// Holds one value. On an insert it keeps its value, takes the operand or takes
// its left neighbor's value; on a removal it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module mhlr_cell (
	input  logic                  clk,
	input  mhlr_pkg::cell_ctl_t   ctl,
	input  logic                  occ,
	input  logic                  left_le,
	input  logic signed [31:0]    left_value,
	input  logic signed [31:0]    right_value,
	output logic signed [31:0]    value,
	output logic                  le,
	output logic                  lt,
	output logic                  hit
);

	logic signed [31:0] value_q;
	logic               hit_q;

	assign value = value_q;
	assign lt    = occ && (value_q < ctl.operand);
	assign le    = occ && (value_q <= ctl.operand);
	assign hit   = hit_q;

	// The row stays sorted ascending, so the cells at or below the operand
	// form a prefix; the first cell past it takes the operand.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			mhlr_pkg::CELL_INSERT: begin
				if (!le) begin
					value_q <= left_le ? ctl.operand : left_value;
				end
			end
			mhlr_pkg::CELL_SHIFT: begin
				value_q <= right_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
		hit_q <= occ && (value_q == ctl.operand);
	end

endmodule

// ===== rtl/mhlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhlr_ctrl: sequencer, entry count and output register
// Takes one request word, decides each result word from the head cell and
// the match flags of the row, and drives the row of cells.
// ----------------------------------------------------------------------------
module mhlr_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  mhlr_pkg::req_word_t               req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output mhlr_pkg::rsp_word_t               rsp,
	input  mhlr_pkg::heap_stat_t              stat,
	output mhlr_pkg::cell_ctl_t               ctl,
	output logic [$clog2(CAPACITY+1)-1:0]     count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	mhlr_pkg::state_t    state_q, state_d;
	mhlr_pkg::req_word_t req_q;
	mhlr_pkg::rsp_word_t rsp_q, word;
	logic                rsp_valid_q;
	logic [CNT_W-1:0]    count_q;
	logic                emit, cnt_inc, cnt_dec;
	logic                out_free, full, empty;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign req_stall = (state_q != mhlr_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count     = count_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mhlr_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = mhlr_pkg::S_LOOK;
				end
			end
			mhlr_pkg::S_LOOK: begin
				state_d = mhlr_pkg::S_DECIDE;
			end
			mhlr_pkg::S_DECIDE: begin
				case (req_q.req_type)
					mhlr_pkg::OP_INSERT: begin
						if (out_free) state_d = mhlr_pkg::S_IDLE;
					end
					mhlr_pkg::OP_REMOVE: begin
						if (out_free) state_d = empty ? mhlr_pkg::S_TAIL : mhlr_pkg::S_IDLE;
					end
					mhlr_pkg::OP_GETMIN: begin
						if (out_free) begin
							if (!stat.present) begin
								state_d = full ? mhlr_pkg::S_IDLE : mhlr_pkg::S_DRAIN;
							end else begin
								state_d = stat.head_below ? mhlr_pkg::S_DRAIN
								                          : mhlr_pkg::S_IDLE;
							end
						end
					end
					default: begin
						state_d = mhlr_pkg::S_IDLE;
					end
				endcase
			end
			mhlr_pkg::S_TAIL: begin
				if (out_free) state_d = mhlr_pkg::S_IDLE;
			end
			mhlr_pkg::S_DRAIN: begin
				if (out_free && !stat.head_below) state_d = mhlr_pkg::S_IDLE;
			end
			default: begin
				state_d = mhlr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		emit          = 1'b0;
		cnt_inc       = 1'b0;
		cnt_dec       = 1'b0;
		ctl.cmd       = mhlr_pkg::CELL_HOLD;
		ctl.operand   = req_q.item_value;
		word.op_code  = req_q.req_type;
		word.op_value = req_q.item_value;
		word.last     = 1'b1;
		word.overflow = 1'b0;
		case (state_q)
			mhlr_pkg::S_DECIDE: begin
				if (out_free) begin
					case (req_q.req_type)
						mhlr_pkg::OP_INSERT: begin
							emit = 1'b1;
							if (full) begin
								word.overflow = 1'b1;
							end else begin
								ctl.cmd = mhlr_pkg::CELL_INSERT;
								cnt_inc = 1'b1;
							end
						end
						mhlr_pkg::OP_REMOVE: begin
							emit = 1'b1;
							if (empty) begin
								word.op_code  = mhlr_pkg::OP_INSERT;
								word.op_value = mhlr_pkg::FILL_VALUE;
								word.last     = 1'b0;
							end else begin
								ctl.cmd       = mhlr_pkg::CELL_SHIFT;
								cnt_dec       = 1'b1;
								word.op_value = '0;
							end
						end
						mhlr_pkg::OP_GETMIN: begin
							emit = 1'b1;
							if (!stat.present) begin
								if (full) begin
									word.overflow = 1'b1;
								end else begin
									ctl.cmd      = mhlr_pkg::CELL_INSERT;
									cnt_inc      = 1'b1;
									word.op_code = mhlr_pkg::OP_INSERT;
									word.last    = 1'b0;
								end
							end else if (stat.head_below) begin
								ctl.cmd       = mhlr_pkg::CELL_SHIFT;
								cnt_dec       = 1'b1;
								word.op_code  = mhlr_pkg::OP_REMOVE;
								word.op_value = '0;
								word.last     = 1'b0;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			mhlr_pkg::S_TAIL: begin
				emit          = out_free;
				word.op_code  = mhlr_pkg::OP_REMOVE;
				word.op_value = '0;
			end
			mhlr_pkg::S_DRAIN: begin
				emit = out_free;
				// The row is sorted, so a value below the operand sits in cell 0.
				if (out_free && stat.head_below) begin
					ctl.cmd       = mhlr_pkg::CELL_SHIFT;
					cnt_dec       = 1'b1;
					word.op_code  = mhlr_pkg::OP_REMOVE;
					word.op_value = '0;
					word.last     = 1'b0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mhlr_pkg::S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mhlr_pkg::S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (emit) begin
			rsp_q <= word;
		end
	end

endmodule

// ===== rtl/mhlr_check.sv =====
// ----------------------------------------------------------------------------
// mhlr_check: port-level checks for min_heap_log_repair_core
// Watches the channel ports for result word rules and handshake order.
// ----------------------------------------------------------------------------
module mhlr_check (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input mhlr_pkg::rsp_word_t rsp
);

	// A refused item produces one word only, so it must close the item.
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.overflow |-> rsp.last)
		else $error("overflow word without last");

	a_ovf_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.overflow |->
		(rsp.op_code == mhlr_pkg::OP_INSERT || rsp.op_code == mhlr_pkg::OP_GETMIN))
		else $error("overflow on a removal word");

	a_remove_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.op_code == mhlr_pkg::OP_REMOVE |-> rsp.op_value == '0)
		else $error("removal word with nonzero value");

	// One item at a time: an accepted word blocks the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second word taken while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed");

endmodule

bind min_heap_log_repair_core mhlr_check u_mhlr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
